### hw/rtl/epsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types and constants for the encoder speed controller.
// ----------------------------------------------------------------------------
package epsc_pkg;

    localparam int PWM_TOP = 1000;

    // floor(mag * PWM_TOP / (100 << 16)) as a reciprocal multiply,
    // exact for any mag up to 100 << 16
    localparam int          DUTY_SHIFT = 46;
    localparam logic [63:0] DUTY_RECIP =
        ((64'(PWM_TOP) << DUTY_SHIFT) + 64'd6553599) / 64'd6553600;

    localparam logic [2:0] REG_FILTER_WEIGHT = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN     = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd3;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [2:0] REG_INV_PERIOD    = 3'd5;
    localparam logic [2:0] REG_SPEED_SCALE   = 3'd6;

    localparam logic signed [95:0] INTEG_LIM = 96'sd3276800;
    localparam logic signed [95:0] OUT_LIM   = 96'sd6553600;
    localparam logic signed [95:0] S32_MAX   = 96'sd2147483647;
    localparam logic signed [95:0] S32_MIN   = -96'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAW,
        ST_MIX_A,
        ST_MIX_B,
        ST_ERR,
        ST_PROP,
        ST_INTEG_ACC,
        ST_INTEG,
        ST_DERIV,
        ST_DERIV_D,
        ST_SUM,
        ST_DUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

endpackage

### hw/rtl/epsc_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsc_serial_mul
// Signed 48 x 48 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module epsc_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  epsc_pkg::mul_ctl_t ctl_in,
    input  logic signed [47:0] op_a,
    input  logic signed [47:0] op_b,
    output logic               done,
    output logic signed [95:0] product
);
    import epsc_pkg::*;

    logic [5:0]         cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic signed [95:0] acc_reg, acc_next;
    logic signed [95:0] mcand_reg, mcand_next;
    logic [47:0]        mplier_reg, mplier_next;

    always_comb begin
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        done        = 1'b0;
        if (ctl_in.start) begin
            run_next    = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = 96'(op_a);
            mplier_next = op_b;
        end else if (run_reg) begin
            // top bit carries negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'd47) begin
                    acc_next = acc_reg - mcand_reg;
                end else begin
                    acc_next = acc_reg + mcand_reg;
                end
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
    end

    assign product = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

### hw/rtl/encoder_pid_speed_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller_unit
// Quadrature edge counter with a filtered PI-D speed loop and PWM duties.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries edge beats (mode 0) and control tick beats (mode 1).
//   An edge beat updates the position count when accepted and gives no beat.
//   A tick beat runs the loop on one shared bit-serial 48x48 multiplier,
//   one bit per cycle: eight products and four single steps (error, sum,
//   duty, output) in turn, and then the m_ beat is valid.
//   With m_ready high the next tick can go in once that beat is taken.
//   Edge beats are not accepted while a tick is running.
//   The result sits in an output register; while m_ready is low the block
//   holds it and accepts no new tick, but edge beats are still counted.
//   Registers are written over APB; pready is always high.
//   Reset (aresetn low, synchronous) clears the counts, filter, integrator,
//   target, FSM and output valid and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic               s_on_channel_b,
    input  logic               s_level_a,
    input  logic               s_level_b,
    input  logic               s_new_target,
    input  logic signed [31:0] s_speed_setpoint,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_measured_speed,
    output logic [9:0]         m_fwd_duty,
    output logic [9:0]         m_rev_duty
);
    import epsc_pkg::*;

    logic [16:0] filter_weight_reg;
    logic [23:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [15:0] sample_period_reg;
    logic [31:0] inv_period_reg, speed_scale_reg;

    logic [31:0]        edge_count_reg, last_count_reg;
    logic signed [31:0] filt_reg, integ_reg, last_err_reg, target_reg;
    logic signed [31:0] err_reg;
    logic signed [95:0] t_reg, p_reg, i_reg;
    logic signed [95:0] u_reg;
    state_t             state_reg, state_next;

    logic               m_valid_reg;
    logic signed [31:0] m_speed_reg;
    logic [9:0]         m_fwd_reg, m_rev_reg;

    mul_ctl_t           mctl;
    logic               mdone;
    logic signed [47:0] ma, mb;
    logic signed [95:0] mprod;

    logic [2:0] reg_idx;
    logic       wr_en;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    function automatic logic signed [95:0] sat32(input logic signed [95:0] x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic logic signed [95:0] clampv(input logic signed [95:0] x,
                                                  input logic signed [95:0] lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    always_comb begin
        case (reg_idx)
            REG_FILTER_WEIGHT: prdata = 32'(filter_weight_reg);
            REG_PROP_GAIN:     prdata = 32'(prop_gain_reg);
            REG_INTEG_GAIN:    prdata = 32'(integ_gain_reg);
            REG_DERIV_GAIN:    prdata = 32'(deriv_gain_reg);
            REG_SAMPLE_PERIOD: prdata = 32'(sample_period_reg);
            REG_INV_PERIOD:    prdata = inv_period_reg;
            REG_SPEED_SCALE:   prdata = speed_scale_reg;
            default:           prdata = '0;
        endcase
    end

    logic edge_ok, tick_ok;
    assign s_ready = (state_reg == ST_IDLE) && (!s_mode || !m_valid_reg);
    assign edge_ok = s_valid && s_ready && !s_mode;
    assign tick_ok = s_valid && s_ready && s_mode;

    logic [16:0]        w_eff;
    logic signed [31:0] delta;
    assign w_eff = filter_weight_reg[16] ? 17'h10000 : filter_weight_reg;
    assign delta = edge_count_reg - last_count_reg;

    // operand select and multiply launch
    logic mul_busy_reg, mul_busy_next;
    always_comb begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_RAW:       begin ma = 48'(delta); mb = 48'($signed({1'b0, speed_scale_reg})); end
            ST_MIX_A:     begin ma = 48'($signed({1'b0, w_eff})); mb = 48'(t_reg); end
            ST_MIX_B:     begin
                ma = 48'($signed(18'h10000 - {1'b0, w_eff})); mb = 48'(filt_reg);
            end
            ST_PROP:      begin ma = 48'($signed({1'b0, prop_gain_reg})); mb = 48'(err_reg); end
            ST_INTEG_ACC: begin
                ma = 48'(err_reg); mb = 48'($signed({1'b0, sample_period_reg}));
            end
            ST_INTEG:     begin ma = 48'($signed({1'b0, integ_gain_reg})); mb = 48'(integ_reg); end
            ST_DERIV:     begin
                ma = 48'($signed({1'b0, deriv_gain_reg}));
                mb = 48'(err_reg) - 48'(last_err_reg);
            end
            ST_DERIV_D:   begin ma = 48'(t_reg); mb = 48'($signed({1'b0, inv_period_reg})); end
            default:      begin ma = '0; mb = '0; end
        endcase
    end

    logic is_mul_state;
    assign is_mul_state = (state_reg == ST_RAW) || (state_reg == ST_MIX_A) ||
                          (state_reg == ST_MIX_B) || (state_reg == ST_PROP) ||
                          (state_reg == ST_INTEG_ACC) || (state_reg == ST_INTEG) ||
                          (state_reg == ST_DERIV) || (state_reg == ST_DERIV_D);
    assign mctl.start = is_mul_state && !mul_busy_reg;
    assign mul_busy_next = is_mul_state && !mdone;

    epsc_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (mctl),
        .op_a    (ma),
        .op_b    (mb),
        .done    (mdone),
        .product (mprod)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (tick_ok) state_next = ST_RAW;
            ST_RAW:       if (mdone) state_next = ST_MIX_A;
            ST_MIX_A:     if (mdone) state_next = ST_MIX_B;
            ST_MIX_B:     if (mdone) state_next = ST_ERR;
            ST_ERR:       state_next = ST_PROP;
            ST_PROP:      if (mdone) state_next = ST_INTEG_ACC;
            ST_INTEG_ACC: if (mdone) state_next = ST_INTEG;
            ST_INTEG:     if (mdone) state_next = ST_DERIV;
            ST_DERIV:     if (mdone) state_next = ST_DERIV_D;
            ST_DERIV_D:   if (mdone) state_next = ST_SUM;
            ST_SUM:       state_next = ST_DUTY;
            ST_DUTY:      state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // |u| is at most 100 << 16, so 23 bits
    logic [22:0] mag;
    logic [95:0] duty_w;
    assign mag    = u_reg < 0 ? 23'(-u_reg) : 23'(u_reg);
    assign duty_w = (96'(mag) * 96'(DUTY_RECIP)) >> DUTY_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_weight_reg <= 17'd16384;
            prop_gain_reg     <= 24'd327680;
            integ_gain_reg    <= 24'd262144;
            deriv_gain_reg    <= '0;
            sample_period_reg <= 16'd655;
            inv_period_reg    <= 32'd6553600;
            speed_scale_reg   <= '0;
            edge_count_reg    <= '0;
            last_count_reg    <= '0;
            filt_reg          <= '0;
            integ_reg         <= '0;
            last_err_reg      <= '0;
            target_reg        <= '0;
            state_reg         <= ST_IDLE;
            mul_busy_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mul_busy_reg <= mul_busy_next;
            if (wr_en) begin
                case (reg_idx)
                    REG_FILTER_WEIGHT: filter_weight_reg <= pwdata[16:0];
                    REG_PROP_GAIN:     prop_gain_reg     <= pwdata[23:0];
                    REG_INTEG_GAIN:    integ_gain_reg    <= pwdata[23:0];
                    REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata[23:0];
                    REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[15:0];
                    REG_INV_PERIOD:    inv_period_reg    <= pwdata;
                    REG_SPEED_SCALE:   speed_scale_reg   <= pwdata;
                    default: ;
                endcase
            end
            if (edge_ok) begin
                if ((s_level_a == s_level_b) ^ s_on_channel_b) begin
                    edge_count_reg <= edge_count_reg + 32'd1;
                end else begin
                    edge_count_reg <= edge_count_reg - 32'd1;
                end
            end
            if (tick_ok && s_new_target) target_reg <= s_speed_setpoint;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_RAW: if (mdone) begin
                    t_reg          <= sat32(mprod);
                    last_count_reg <= edge_count_reg;
                end
                ST_MIX_A: if (mdone) t_reg <= mprod;
                ST_MIX_B: if (mdone) filt_reg <= 32'(sat32((t_reg + mprod) >>> 16));
                ST_ERR: err_reg <= 32'(sat32(96'(target_reg) - 96'(filt_reg)));
                ST_PROP: if (mdone) p_reg <= mprod >>> 16;
                ST_INTEG_ACC: if (mdone) begin
                    integ_reg <= 32'(clampv(96'(integ_reg) + (mprod >>> 16), INTEG_LIM));
                end
                ST_INTEG: if (mdone) i_reg <= mprod >>> 16;
                ST_DERIV: if (mdone) t_reg <= sat32(mprod >>> 16);
                ST_DERIV_D: if (mdone) begin
                    t_reg        <= mprod >>> 16;
                    last_err_reg <= err_reg;
                end
                ST_SUM: u_reg <= clampv(p_reg + i_reg + t_reg, OUT_LIM);
                ST_DUTY: begin
                    m_speed_reg <= filt_reg;
                    m_fwd_reg   <= (u_reg > 0) ? 10'(duty_w > 96'd1023 ? 96'd1023 : duty_w)
                                               : 10'd0;
                    m_rev_reg   <= (u_reg < 0) ? 10'(duty_w > 96'd1023 ? 96'd1023 : duty_w)
                                               : 10'd0;
                end
                ST_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_measured_speed = m_speed_reg;
    assign m_fwd_duty       = m_fwd_reg;
    assign m_rev_duty       = m_rev_reg;

endmodule

### verif/tb_encoder_pid_speed_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_pid_speed_controller_unit
// Self-checking bench for the encoder speed controller: counts quadrature
// edges and runs PI-D ticks through a local Q16.16 predictor, compares every
// result beat field by field, and sweeps the APB registers between phases.
// ----------------------------------------------------------------------------
module tb_encoder_pid_speed_controller_unit;
    import epsc_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        mode;
        logic        on_channel_b;
        logic        level_a;
        logic        level_b;
        logic        new_target;
        logic [31:0] setpoint;
    } beat_t;

    typedef struct packed {
        logic [31:0] speed;
        logic [9:0]  fwd;
        logic [9:0]  rev;
    } speed_out_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic        s_mode, s_on_channel_b, s_level_a, s_level_b, s_new_target;
    logic signed [31:0] s_speed_setpoint;
    logic        m_valid, m_ready;
    logic signed [31:0] m_measured_speed;
    logic [9:0]  m_fwd_duty, m_rev_duty;

    encoder_pid_speed_controller_unit u_dut (.*);

    // predictor state
    longint unsigned cfg_weight, cfg_kp, cfg_ki, cfg_kd, cfg_period, cfg_inv, cfg_scale;
    logic [31:0] pos_count, pos_at_tick;
    longint      filt_speed, integ_sum, prev_error, target_hold;

    beat_t      pending_beats[$];
    speed_out_t expected_outs[$];
    int         mismatches;
    int         send_idle_pct, recv_idle_pct;
    int         wdog;
    bit         sender_hold;

    function automatic longint floor_q16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_s32(longint x);
        return clip(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    task automatic predict_beat(beat_t b);
        logic        same, up;
        longint      delta, raw, w, mix, err, p, i, kd_de, d, u, mag, duty, acc;
        speed_out_t  o;
        if (!b.mode) begin
            same = (b.level_a == b.level_b);
            up = b.on_channel_b ? !same : same;
            pos_count = up ? pos_count + 32'd1 : pos_count - 32'd1;
            return;
        end
        if (b.new_target) target_hold = longint'($signed(b.setpoint));
        delta = longint'($signed(pos_count - pos_at_tick));
        pos_at_tick = pos_count;
        raw = sat_s32(delta * longint'(cfg_scale));
        w = cfg_weight > 65536 ? 65536 : longint'(cfg_weight);
        mix = w * raw + (65536 - w) * filt_speed;
        filt_speed = sat_s32(floor_q16(mix));
        err = sat_s32(target_hold - filt_speed);
        p = floor_q16(longint'(cfg_kp) * err);
        acc = integ_sum + floor_q16(err * longint'(cfg_period));
        integ_sum = clip(acc, -64'sd3276800, 64'sd3276800);
        i = floor_q16(longint'(cfg_ki) * integ_sum);
        kd_de = sat_s32(floor_q16(longint'(cfg_kd) * (err - prev_error)));
        // kd_de * inv_period can come close to 2^63; split to keep it exact
        d = floor_q16(kd_de * longint'(cfg_inv >> 16)) * 65536
            + kd_de * longint'(cfg_inv >> 16) - floor_q16(kd_de * longint'(cfg_inv >> 16)) * 65536;
        d = kd_de * longint'(cfg_inv >> 16) + floor_q16(kd_de * longint'(cfg_inv & 16'hFFFF));
        prev_error = err;
        u = clip(p + i + d, -64'sd6553600, 64'sd6553600);
        mag = u < 0 ? -u : u;
        duty = (mag * PWM_TOP) / 6553600;
        if (duty > 1023) duty = 1023;
        o.speed = filt_speed[31:0];
        o.fwd = u > 0 ? duty[9:0] : 10'd0;
        o.rev = u < 0 ? duty[9:0] : 10'd0;
        expected_outs.push_back(o);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_beats.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                predict_beat(b);
                s_valid <= 1'b1;
                {s_mode, s_on_channel_b, s_level_a, s_level_b, s_new_target,
                 s_speed_setpoint} <= b;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        speed_out_t e;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (m_valid && m_ready) begin
                if (expected_outs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat");
                end else begin
                    e = expected_outs.pop_front();
                    if (e.speed !== m_measured_speed || e.fwd !== m_fwd_duty ||
                        e.rev !== m_rev_duty) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp spd %h fwd %0d rev %0d, got %h %0d %0d",
                                     e.speed, e.fwd, e.rev, m_measured_speed,
                                     m_fwd_duty, m_rev_duty);
                    end
                end
            end
            if (wdog >= WDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FILTER_WEIGHT: cfg_weight = 64'(val[16:0]);
            REG_PROP_GAIN:     cfg_kp     = 64'(val[23:0]);
            REG_INTEG_GAIN:    cfg_ki     = 64'(val[23:0]);
            REG_DERIV_GAIN:    cfg_kd     = 64'(val[23:0]);
            REG_SAMPLE_PERIOD: cfg_period = 64'(val[15:0]);
            REG_INV_PERIOD:    cfg_inv    = 64'(val);
            REG_SPEED_SCALE:   cfg_scale  = 64'(val);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_outs.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic beat_t edge_beat(bit chb, bit la, bit lb);
        beat_t b;
        b = '0;
        b.on_channel_b = chb; b.level_a = la; b.level_b = lb;
        b.new_target = 1'($urandom_range(1)); b.setpoint = $urandom;
        return b;
    endfunction

    function automatic beat_t tick_beat(bit load, logic [31:0] tgt);
        beat_t b;
        b.mode = 1'b1; b.new_target = load; b.setpoint = tgt;
        b.on_channel_b = 1'($urandom_range(1)); b.level_a = 1'($urandom_range(1));
        b.level_b = 1'($urandom_range(1));
        return b;
    endfunction

    // quadrature walks with random length and direction, each then a tick, mixed with stray edge beats
    task automatic queue_random(int n);
        bit a, bb, dir;
        int k;
        a = 0; bb = 0;
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(9) == 0) begin
                pending_beats.push_back(edge_beat(1'($urandom_range(1)),
                                                  1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
                continue;
            end
            dir = 1'($urandom_range(1));
            k = $urandom_range(4);
            if ($urandom_range(19) == 0) k = $urandom_range(200, 40);
            for (int q = 0; q < k; q++) begin
                if (dir ^ (a == bb)) begin
                    bb = !bb; pending_beats.push_back(edge_beat(1, a, bb));
                end else begin
                    a = !a; pending_beats.push_back(edge_beat(0, a, bb));
                end
            end
            case ($urandom_range(3))
                0: pending_beats.push_back(tick_beat(1'($urandom_range(1)), $urandom));
                1: pending_beats.push_back(tick_beat(1, 32'($signed($urandom_range(0, 20000000))
                                                     - 10000000)));
                default: pending_beats.push_back(tick_beat(1'($urandom_range(1)),
                                                  32'($signed($urandom_range(0, 800000)) - 400000)));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_mode = 1'b0; s_on_channel_b = 1'b0; s_level_a = 1'b0;
        s_level_b = 1'b0; s_new_target = 1'b0; s_speed_setpoint = '0;
        m_ready = 1'b0;
        mismatches = 0; wdog = 0; sender_hold = 1'b0;
        send_idle_pct = 17; recv_idle_pct = 45;
        cfg_weight = 16384; cfg_kp = 327680; cfg_ki = 262144; cfg_kd = 0;
        cfg_period = 655; cfg_inv = 6553600; cfg_scale = 0;
        pos_count = '0; pos_at_tick = '0;
        filt_speed = 0; integ_sum = 0; prev_error = 0; target_hold = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults, every edge rule, target extremes
        for (int c = 0; c < 8; c++)
            pending_beats.push_back(edge_beat(c[2], c[1], c[0]));
        pending_beats.push_back(tick_beat(1, 32'h7FFFFFFF));
        pending_beats.push_back(tick_beat(0, 32'h0));
        pending_beats.push_back(tick_beat(1, 32'h80000000));
        pending_beats.push_back(tick_beat(1, 32'h0));
        wait_drained();

        apb_write(REG_SPEED_SCALE, 32'h0001_0000);
        apb_write(REG_DERIV_GAIN, 32'h0001_0000);
        apb_write(REG_FILTER_WEIGHT, 32'h0001_FFFF);
        for (int c = 0; c < 6; c++) pending_beats.push_back(edge_beat(0, 1, 1));
        pending_beats.push_back(tick_beat(1, 32'h0050_0000));
        pending_beats.push_back(tick_beat(1, 32'hFFB0_0000));
        pending_beats.push_back(tick_beat(0, 32'h0));
        wait_drained();

        apb_write(REG_FILTER_WEIGHT, 0);
        apb_write(REG_PROP_GAIN, 32'h00FF_FFFF);
        apb_write(REG_INTEG_GAIN, 32'h00FF_FFFF);
        apb_write(REG_DERIV_GAIN, 32'h00FF_FFFF);
        apb_write(REG_SAMPLE_PERIOD, 0);
        apb_write(REG_INV_PERIOD, 32'hFFFFFFFF);
        apb_write(REG_SPEED_SCALE, 32'hFFFFFFFF);
        queue_random(20);
        wait_drained();

        send_idle_pct = 45; recv_idle_pct = 17;
        apb_write(REG_FILTER_WEIGHT, 65536);
        apb_write(REG_PROP_GAIN, 0);
        apb_write(REG_INTEG_GAIN, 0);
        apb_write(REG_DERIV_GAIN, 0);
        apb_write(REG_SAMPLE_PERIOD, 32'h0000_FFFF);
        apb_write(REG_INV_PERIOD, 0);
        apb_write(REG_SPEED_SCALE, 32'h0004_0000);
        queue_random(20);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            apb_write(REG_FILTER_WEIGHT, $urandom_range(65536));
            apb_write(REG_PROP_GAIN, $urandom_range(24'h0FFFFF));
            apb_write(REG_INTEG_GAIN, $urandom_range(24'h0FFFFF));
            apb_write(REG_DERIV_GAIN, $urandom_range(24'h03FFFF));
            apb_write(REG_SAMPLE_PERIOD, $urandom_range(65535, 1));
            apb_write(REG_INV_PERIOD, $urandom);
            apb_write(REG_SPEED_SCALE, $urandom_range(32'h0100_0000));
            queue_random(10);
            // sender holds off until the pipeline empties
            while (pending_beats.size() > 30) @(posedge aclk);
            sender_hold = 1'b1;
            while (s_valid || expected_outs.size() != 0) @(posedge aclk);
            sender_hold = 1'b0;
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/epsc_pkg.sv
hw/rtl/epsc_serial_mul.sv
hw/rtl/encoder_pid_speed_controller_unit.sv
verif/tb_encoder_pid_speed_controller_unit.sv
